// ===== rtl/ssp_pkg.sv =====
// Shared constants, widths and types of the sphere pair penetration block.
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int RAD_WIDTH   = COORD_WIDTH - 2;
  localparam int DIST_WIDTH  = COORD_WIDTH - 1;
  localparam int NORM_WIDTH  = FRAC_BITS + 2;
  localparam int AW          = COORD_WIDTH + 1;   // |d_i| magnitude
  localparam int SQW         = 2 * AW;            // sum of squares
  localparam int ROOTW       = AW;                // floor sqrt
  localparam int QW          = FRAC_BITS + 1;     // unit vector magnitude
  localparam int MAGW        = COORD_WIDTH;       // |depth - skin|

  localparam int IN_FIELDS_W  = 6 * COORD_WIDTH + 3 * RAD_WIDTH;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DIST_WIDTH + 3 * NORM_WIDTH + 7 * COORD_WIDTH;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic en;
    logic vld;
  } ssp_ctl_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] dyn;
    logic [2:0]                  neg;
    logic [2:0][AW-1:0]          amag;
    logic [RAD_WIDTH-1:0]        r_dyn;
    logic [RAD_WIDTH-1:0]        skin;
    logic [RAD_WIDTH-1:0]        r_st;
  } ssp_sq_side_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] dyn;
    logic [2:0]                  neg;
    logic [RAD_WIDTH-1:0]        r_dyn;
    logic [RAD_WIDTH-1:0]        skin;
    logic                        hit;
    logic                        zero;
    logic [DIST_WIDTH-1:0]       cdist;
    logic [COORD_WIDTH-1:0]      depth;
  } ssp_dv_side_t;

endpackage

// ===== rtl/sphere_sphere_penetration.sv =====
// Top level of the sphere pair penetration pipeline.
// Usage:
//   Input channel in_*: one sphere pair per item, fields packed in in_tdata.
//   Output channel out_*: one result per item; out_tuser carries the hit flag,
//   out_tdata the distance, normal, depth, safe position and contact point.
//   When there is no overlap every tdata bit of the result is zero.
// Stages: 3 front stages, 33 square root stages (one root bit each),
//   1 hit stage, 17 divider stages (one quotient bit each) and 3 back
//   stages.
// Throughput: one item per cycle; every stage is a register slice that
//   advances whenever the output register is empty or being taken.
// Reset: rst_n (synchronous, active low) clears all valid bits; the data
//   registers are not reset.
// Stall: while out_tvalid is high and out_tready is low the whole pipeline
//   holds, in_tready is low, and no item is lost or repeated.
`timescale 1ns / 1ps
module sphere_sphere_penetration (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // dyn_x, dyn_y, dyn_z, dyn_radius, skin_width, stat_x, stat_y, stat_z,
  // stat_radius, zero fill
  input  logic [ssp_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // centre_distance, normal_x, normal_y, normal_z, pen_depth, safe_x, safe_y,
  // safe_z, contact_x, contact_y, contact_z, zero fill
  output logic [ssp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // hit
  output logic                              out_tuser
);
  import ssp_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int RW     = RAD_WIDTH;
  localparam int OFF_DR = 3 * CW;
  localparam int OFF_SK = OFF_DR + RW;
  localparam int OFF_ST = OFF_SK + RW;
  localparam int OFF_SR = OFF_ST + 3 * CW;
  localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;

  function automatic logic [CW-1:0] sat_coord(input logic [CW+2:0] v);
    logic [CW-1:0] res;
    if (!v[CW+2] && (|v[CW+1:CW-1])) begin
      res = {1'b0, {(CW-1){1'b1}}};
    end else if (v[CW+2] && !(&v[CW+1:CW-1])) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: differences and magnitudes
  ssp_sq_side_t s1_r;
  logic         v1_r;
  // stage 2: squares
  ssp_sq_side_t s2_r;
  logic [2:0][SQW-1:0] sq_r;
  logic         v2_r;
  // stage 3: sum of squares
  ssp_sq_side_t s3_r;
  logic [SQW-1:0] sum_r;
  logic         v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [CW-1:0] dv;
    logic [CW-1:0] sv;
    logic [AW-1:0] dw;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv = in_tdata[i*CW +: CW];
        sv = in_tdata[OFF_ST + i*CW +: CW];
        dw = {sv[CW-1], sv} - {dv[CW-1], dv};
        s1_r.dyn[i]  <= dv;
        s1_r.neg[i]  <= dw[AW-1];
        s1_r.amag[i] <= dw[AW-1] ? (~dw + 1'b1) : dw;
      end
      s1_r.r_dyn <= in_tdata[OFF_DR +: RW];
      s1_r.skin  <= in_tdata[OFF_SK +: RW];
      s1_r.r_st  <= in_tdata[OFF_SR +: RW];
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= s1_r.amag[i] * s1_r.amag[i];
      end
      s2_r  <= s1_r;
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
      s3_r  <= s2_r;
    end
  end

  logic             sq_vld;
  logic [ROOTW-1:0] root;
  ssp_sq_side_t     sq_side;

  ssp_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    ('{en: adv, vld: v3_r}),
    .rad    (sum_r),
    .side   (s3_r),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  // stage 4: hit test and depth
  ssp_dv_side_t      s4_r;
  logic [2:0][AW-1:0] num_r;
  logic [AW-1:0]     den_r;
  logic              v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    logic [RW:0]    rsum;
    logic [ROOTW:0] dep;
    if (adv) begin
      rsum = {1'b0, sq_side.r_dyn} + {1'b0, sq_side.r_st};
      dep  = {1'b0, root} - {{(ROOTW-RW){1'b0}}, rsum};
      s4_r.dyn   <= sq_side.dyn;
      s4_r.neg   <= sq_side.neg;
      s4_r.r_dyn <= sq_side.r_dyn;
      s4_r.skin  <= sq_side.skin;
      s4_r.hit   <= (root < {{(ROOTW-RW-1){1'b0}}, rsum});
      s4_r.zero  <= (root == '0);
      s4_r.cdist <= root[DIST_WIDTH-1:0];
      s4_r.depth <= dep[CW-1:0];
      num_r      <= sq_side.amag;
      den_r      <= root;
    end
  end

  logic               dv_vld;
  logic [2:0][QW-1:0] q;
  ssp_dv_side_t       dv_side;

  ssp_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    ('{en: adv, vld: v4_r}),
    .num    (num_r),
    .den    (den_r),
    .side   (s4_r),
    .vld_o  (dv_vld),
    .q_o    (q),
    .side_o (dv_side)
  );

  // stage 5: products
  logic [2:0][QW+MAGW-1:0] p_safe_r;
  logic [2:0][QW+RW-1:0]   p_ct_r;
  logic [2:0][QW-1:0]      umag5_r;
  logic                    mneg5_r;
  ssp_dv_side_t            s5_r;
  logic                    v5_r;
  // stage 6: safe position, scaled contact offset and normal
  logic [2:0][CW+1:0]      safe6_r;
  logic [2:0][CW+1:0]      ct6_r;
  logic [2:0][NORM_WIDTH-1:0] nrm6_r;
  ssp_dv_side_t            s6_r;
  logic                    v6_r;
  // stage 7: output register
  logic                       hit_o_r;
  logic [DIST_WIDTH-1:0]      dist_o_r;
  logic [2:0][NORM_WIDTH-1:0] nrm_o_r;
  logic [CW-1:0]              depth_o_r;
  logic [2:0][CW-1:0]         safe_o_r;
  logic [2:0][CW-1:0]         ct_o_r;
  logic                       v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v5_r <= dv_vld;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0]   um;
    logic [CW:0]     m;
    logic [CW:0]     mm;
    logic [MAGW-1:0] smag;
    logic [CW+1:0]   sc;
    logic [RW-1:0]   cmag;
    logic [CW+2:0]   cont;
    logic [CW+2:0]   safe_x;
    if (adv) begin
      m  = {dv_side.depth[CW-1], dv_side.depth} - {3'b000, dv_side.skin};
      mm = m[CW] ? (~m + 1'b1) : m;
      for (int i = 0; i < 3; i++) begin
        um = dv_side.zero ? '0 : q[i];
        umag5_r[i]  <= um;
        p_safe_r[i] <= um * mm[MAGW-1:0];
        p_ct_r[i]   <= um * dv_side.r_dyn;
      end
      mneg5_r <= m[CW];
      s5_r    <= dv_side;

      for (int i = 0; i < 3; i++) begin
        smag = p_safe_r[i][FRAC_BITS +: MAGW];
        sc   = {2'b00, smag};
        if (s5_r.neg[i] ^ mneg5_r) begin
          sc = ~sc + 1'b1;
        end
        safe6_r[i] <= {{2{s5_r.dyn[i][CW-1]}}, s5_r.dyn[i]} + sc;
        cmag = p_ct_r[i][FRAC_BITS +: RW];
        ct6_r[i] <= s5_r.neg[i] ? (~{4'b0000, cmag} + 1'b1) : {4'b0000, cmag};
        nrm6_r[i] <= s5_r.neg[i] ? {1'b0, umag5_r[i]} : (~{1'b0, umag5_r[i]} + 1'b1);
      end
      s6_r <= s5_r;

      hit_o_r   <= s6_r.hit;
      dist_o_r  <= s6_r.hit ? s6_r.cdist : '0;
      depth_o_r <= s6_r.hit ? s6_r.depth : '0;
      for (int i = 0; i < 3; i++) begin
        safe_x = {safe6_r[i][CW+1], safe6_r[i]};
        cont   = safe_x + {ct6_r[i][CW+1], ct6_r[i]};
        nrm_o_r[i]  <= s6_r.hit ? nrm6_r[i] : '0;
        safe_o_r[i] <= s6_r.hit ? sat_coord(safe_x) : '0;
        ct_o_r[i]   <= s6_r.hit ? sat_coord(cont) : '0;
      end
    end
  end

  assign out_tvalid = v7_r;
  assign out_tuser  = hit_o_r;
  assign out_tdata  = {{PAD_W{1'b0}}, ct_o_r[2], ct_o_r[1], ct_o_r[0],
                       safe_o_r[2], safe_o_r[1], safe_o_r[0], depth_o_r,
                       nrm_o_r[2], nrm_o_r[1], nrm_o_r[0], dist_o_r};

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries nonzero data");

  a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> depth_o_r[CW-1])
    else $error("hit with nonnegative depth");

  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && dist_o_r == '0 |-> nrm_o_r == '0)
    else $error("coincident centres with nonzero normal");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v6_r) && $stable(s6_r.hit))
    else $error("pipeline moved while stalled");

endmodule

// ===== rtl/ssp_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, with sideband.
`timescale 1ns / 1ps
module ssp_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssp_pkg::ssp_ctl_t           ctl,
  input  logic [ssp_pkg::SQW-1:0]     rad,
  input  ssp_pkg::ssp_sq_side_t       side,
  output logic                        vld_o,
  output logic [ssp_pkg::ROOTW-1:0]   root_o,
  output ssp_pkg::ssp_sq_side_t       side_o
);
  import ssp_pkg::*;

  localparam int RMW = ROOTW + 2;

  logic [SQW-1:0]   x_r    [ROOTW];
  logic [RMW-1:0]   rem_r  [ROOTW];
  logic [ROOTW-1:0] root_r [ROOTW];
  ssp_sq_side_t     side_r [ROOTW];
  logic [ROOTW-1:0] vld_r;

  for (genvar k = 0; k < ROOTW; k++) begin : g_stage
    logic [SQW-1:0]   x_in;
    logic [RMW-1:0]   rem_in;
    logic [ROOTW-1:0] root_in;
    ssp_sq_side_t     side_in;
    logic             vld_in;
    logic [RMW-1:0]   rem_s;
    logic [RMW-1:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign x_in    = rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side;
      assign vld_in  = ctl.vld;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign rem_s = {rem_in[RMW-3:0], x_in[SQW-1:SQW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rem_s >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        x_r[k]    <= {x_in[SQW-3:0], 2'b00};
        rem_r[k]  <= ge ? (rem_s - trial) : rem_s;
        root_r[k] <= {root_in[ROOTW-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[ROOTW-1];
  assign root_o = root_r[ROOTW-1];
  assign side_o = side_r[ROOTW-1];

endmodule

// ===== rtl/ssp_div.sv =====
// Pipelined three-lane fractional divider for the unit vector, one bit per stage.
`timescale 1ns / 1ps
module ssp_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssp_pkg::ssp_ctl_t                ctl,
  input  logic [2:0][ssp_pkg::AW-1:0]      num,
  input  logic [ssp_pkg::AW-1:0]           den,
  input  ssp_pkg::ssp_dv_side_t            side,
  output logic                             vld_o,
  output logic [2:0][ssp_pkg::QW-1:0]      q_o,
  output ssp_pkg::ssp_dv_side_t            side_o
);
  import ssp_pkg::*;

  logic [2:0][AW:0]   rem_r  [QW];
  logic [2:0][QW-1:0] q_r    [QW];
  logic [AW-1:0]      den_r  [QW];
  ssp_dv_side_t       side_r [QW];
  logic [QW-1:0]      vld_r;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [2:0][AW:0]   rem_in;
    logic [2:0][QW-1:0] q_in;
    logic [AW-1:0]      den_in;
    ssp_dv_side_t       side_in;
    logic               vld_in;
    logic [2:0][AW:0]   rem_nxt;
    logic [2:0][QW-1:0] q_nxt;

    if (k == 0) begin : g_first
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = {1'b0, num[j]};
      end
      assign q_in    = '0;
      assign den_in  = den;
      assign side_in = side;
      assign vld_in  = ctl.vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      logic [AW:0] rs;
      logic        ge;
      for (int j = 0; j < 3; j++) begin
        rs = (k == 0) ? rem_in[j] : {rem_in[j][AW-1:0], 1'b0};
        ge = (rs >= {1'b0, den_in});
        rem_nxt[j] = ge ? (rs - {1'b0, den_in}) : rs;
        q_nxt[j]   = {q_in[j][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[QW-1];
  assign q_o    = q_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule
